FILE: rtl/kmcu_pkg.sv
package kmcu_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int CLU_W        = $clog2(MAX_CLUSTERS);
    localparam int CH_W         = 8;
    localparam int SUM_W        = 32;
    localparam int CNT_W        = 24;
    localparam int MEAN_W       = 16;
    localparam int FRAC_W       = 8;
    localparam int CFG_W        = 5;
    localparam int STEP_W       = $clog2(MEAN_W);

    localparam logic [CNT_W-1:0] MAX_POINTS    = CNT_W'(16777215);
    localparam logic [CFG_W-1:0] CC_RESET      = CFG_W'(6);
    localparam logic [CFG_W-1:0] CC_MAX        = CFG_W'(MAX_CLUSTERS);

    typedef struct packed {
        logic [SUM_W-1:0] sum_blue;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_red;
        logic [CNT_W-1:0] count;
    } t_acc;

    localparam int ACC_W = $bits(t_acc);

endpackage

FILE: rtl/kmcu_ram.sv
module kmcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kmeans_centroid_update_core.sv
// Accumulation takes one pixel request per cycle; a pixel is written back in the cycle after it is
// accepted, with forwarding when consecutive pixels hit the same cluster.
// On the last pixel of a frame each cluster in use goes through one memory read, one load and a
// bit-serial division of the three channels in parallel by the shared count, then the result.
// Input is stalled from the last pixel until the final result has been taken.
// Reset (synchronous, active low) sets the cluster count to 6 and marks every cluster empty.
module kmeans_centroid_update_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [kmcu_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [kmcu_pkg::CLU_W-1:0]     i_cluster_index,
    input  logic [kmcu_pkg::CH_W-1:0]      i_blue,
    input  logic [kmcu_pkg::CH_W-1:0]      i_green,
    input  logic [kmcu_pkg::CH_W-1:0]      i_red,
    input  logic                           i_last_point,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [kmcu_pkg::CLU_W-1:0]     o_out_cluster,
    output logic [kmcu_pkg::MEAN_W-1:0]    o_mean_blue,
    output logic [kmcu_pkg::MEAN_W-1:0]    o_mean_green,
    output logic [kmcu_pkg::MEAN_W-1:0]    o_mean_red,
    output logic                           o_empty_cluster,
    output logic                           o_last_result
);

    import kmcu_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    localparam int REM_W = CNT_W;
    localparam int STEP_RES_W = REM_W + MEAN_W;

    t_state              r_state;
    logic [CFG_W-1:0]    r_cc;
    logic [MAX_CLUSTERS-1:0] r_vld;

    logic                r_s1_valid;
    logic                r_s1_last;
    logic [CLU_W-1:0]    r_s1_idx;
    logic [CH_W-1:0]     r_s1_blue;
    logic [CH_W-1:0]     r_s1_green;
    logic [CH_W-1:0]     r_s1_red;

    logic                r_wb_valid;
    logic [CLU_W-1:0]    r_wb_idx;
    t_acc                r_wb_data;

    logic [CLU_W-1:0]    r_k;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    r_cnt;
    logic [REM_W-1:0]    r_rem_b, r_rem_g, r_rem_r;
    logic [MEAN_W-1:0]   r_dq_b, r_dq_g, r_dq_r;

    logic                r_out_valid;
    logic [CLU_W-1:0]    r_out_cluster;
    logic [MEAN_W-1:0]   r_mean_b, r_mean_g, r_mean_r;
    logic                r_out_empty;
    logic                r_out_last;

    t_acc                w_rdata;
    t_acc                w_old;
    t_acc                n_acc;
    t_acc                w_load;
    logic                w_we;
    logic [CLU_W-1:0]    w_raddr;
    logic [CFG_W-1:0]    w_n;
    logic                w_k_last;
    logic [STEP_RES_W-1:0] n_step_b, n_step_g, n_step_r;

    function automatic logic [STEP_RES_W-1:0] div_step(
        input logic [REM_W-1:0]  rem,
        input logic [MEAN_W-1:0] dq,
        input logic [CNT_W-1:0]  c
    );
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        logic           ge;
        trial = {rem, dq[MEAN_W-1]};
        ge    = trial >= {1'b0, c};
        diff  = trial - {1'b0, c};
        return {(ge ? diff[REM_W-1:0] : trial[REM_W-1:0]), dq[MEAN_W-2:0], ge};
    endfunction

    kmcu_ram #(
        .WIDTH(ACC_W),
        .DEPTH(MAX_CLUSTERS)
    ) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_s1_idx),
        .i_wdata(n_acc),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_raddr = (r_state == ST_ACCUM) ? i_cluster_index : r_k;

        if (r_wb_valid && (r_wb_idx == r_s1_idx)) begin
            w_old = r_wb_data;
        end else if (r_vld[r_s1_idx]) begin
            w_old = w_rdata;
        end else begin
            w_old = '0;
        end

        n_acc.sum_blue  = w_old.sum_blue + SUM_W'(r_s1_blue);
        n_acc.sum_green = w_old.sum_green + SUM_W'(r_s1_green);
        n_acc.sum_red   = w_old.sum_red + SUM_W'(r_s1_red);
        n_acc.count     = w_old.count + CNT_W'(1);

        w_we = r_s1_valid && (w_old.count != MAX_POINTS);

        w_load = r_vld[r_k] ? w_rdata : '0;

        if (r_cc == '0) begin
            w_n = CFG_W'(1);
        end else if (r_cc > CC_MAX) begin
            w_n = CC_MAX;
        end else begin
            w_n = r_cc;
        end
        w_k_last = ({1'b0, r_k} + CFG_W'(1)) == w_n;

        n_step_b = div_step(r_rem_b, r_dq_b, r_cnt);
        n_step_g = div_step(r_rem_g, r_dq_g, r_cnt);
        n_step_r = div_step(r_rem_r, r_dq_r, r_cnt);
    end

    assign o_in_stall = (r_state != ST_ACCUM) || (r_s1_valid && r_s1_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_cc        <= CC_RESET;
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_step      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cc <= i_cfg_wr_data;
            end

            r_wb_valid <= w_we;
            r_wb_idx   <= r_s1_idx;
            r_wb_data  <= n_acc;
            if (w_we) begin
                r_vld[r_s1_idx] <= 1'b1;
            end

            r_s1_valid <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                r_s1_idx   <= i_cluster_index;
                r_s1_blue  <= i_blue;
                r_s1_green <= i_green;
                r_s1_red   <= i_red;
                r_s1_last  <= i_last_point;
            end

            case (r_state)
                ST_ACCUM: begin
                    if (r_s1_valid && r_s1_last) begin
                        r_k     <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_cnt   <= w_load.count;
                    r_rem_b <= w_load.sum_blue[SUM_W-1:FRAC_W];
                    r_rem_g <= w_load.sum_green[SUM_W-1:FRAC_W];
                    r_rem_r <= w_load.sum_red[SUM_W-1:FRAC_W];
                    r_dq_b  <= {w_load.sum_blue[FRAC_W-1:0], FRAC_W'(0)};
                    r_dq_g  <= {w_load.sum_green[FRAC_W-1:0], FRAC_W'(0)};
                    r_dq_r  <= {w_load.sum_red[FRAC_W-1:0], FRAC_W'(0)};
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem_b <= n_step_b[STEP_RES_W-1:MEAN_W];
                    r_rem_g <= n_step_g[STEP_RES_W-1:MEAN_W];
                    r_rem_r <= n_step_r[STEP_RES_W-1:MEAN_W];
                    r_dq_b  <= n_step_b[MEAN_W-1:0];
                    r_dq_g  <= n_step_g[MEAN_W-1:0];
                    r_dq_r  <= n_step_r[MEAN_W-1:0];
                    r_step  <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(MEAN_W - 1)) begin
                        r_out_valid   <= 1'b1;
                        r_out_cluster <= r_k;
                        r_out_empty   <= (r_cnt == '0);
                        r_out_last    <= w_k_last;
                        r_mean_b      <= (r_cnt == '0) ? '0 : n_step_b[MEAN_W-1:0];
                        r_mean_g      <= (r_cnt == '0) ? '0 : n_step_g[MEAN_W-1:0];
                        r_mean_r      <= (r_cnt == '0) ? '0 : n_step_r[MEAN_W-1:0];
                        r_state       <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_vld   <= '0;
                            r_state <= ST_ACCUM;
                        end else begin
                            r_k     <= r_k + CLU_W'(1);
                            r_state <= ST_READ;
                        end
                    end
                end
                default: begin
                    r_state <= ST_ACCUM;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_cluster   = r_out_cluster;
    assign o_mean_blue     = r_mean_b;
    assign o_mean_green    = r_mean_g;
    assign o_mean_red      = r_mean_r;
    assign o_empty_cluster = r_out_empty;
    assign o_last_result   = r_out_last;

endmodule

FILE: sim/kmeans_centroid_update_core_tb.sv
`timescale 1ns / 100ps

module kmeans_centroid_update_core_tb;

    import kmcu_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 25;

    typedef struct packed {
        logic [CLU_W-1:0] cluster;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic             last_flag;
    } t_pixel;

    typedef struct packed {
        logic [CLU_W-1:0]  cluster;
        logic [MEAN_W-1:0] mean_blue;
        logic [MEAN_W-1:0] mean_green;
        logic [MEAN_W-1:0] mean_red;
        logic              empty_flag;
        logic              last_flag;
    } t_centroid;

    class t_centroid_scoreboard;
        logic [SUM_W-1:0] blue_sum [MAX_CLUSTERS];
        logic [SUM_W-1:0] green_sum [MAX_CLUSTERS];
        logic [SUM_W-1:0] red_sum [MAX_CLUSTERS];
        logic [CNT_W-1:0] pixel_count [MAX_CLUSTERS];
        logic [CFG_W-1:0] cluster_count;
        t_centroid        pending [$];
        int               mismatches;

        function new();
            cluster_count = CC_RESET;
            mismatches    = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            for (int k = 0; k < MAX_CLUSTERS; k++) begin
                blue_sum[k]    = '0;
                green_sum[k]   = '0;
                red_sum[k]     = '0;
                pixel_count[k] = '0;
            end
        endfunction

        function void set_cluster_count(logic [CFG_W-1:0] value);
            cluster_count = value;
        endfunction

        function int clusters_in_use();
            if (cluster_count == 0) return 1;
            if (cluster_count > CC_MAX) return MAX_CLUSTERS;
            return int'(cluster_count);
        endfunction

        function logic [MEAN_W-1:0] mean_8p8(logic [SUM_W-1:0] total, logic [CNT_W-1:0] count);
            logic [SUM_W+FRAC_W-1:0] quotient;
            if (count == 0) return '0;
            quotient = {total, {FRAC_W{1'b0}}} / (SUM_W + FRAC_W)'(count);
            if (quotient > (SUM_W + FRAC_W)'(16'hFFFF)) return 16'hFFFF;
            return quotient[MEAN_W-1:0];
        endfunction

        function void note_pixel(t_pixel px);
            int        n;
            t_centroid c;
            if (pixel_count[px.cluster] != MAX_POINTS) begin
                blue_sum[px.cluster]    += SUM_W'(px.blue);
                green_sum[px.cluster]   += SUM_W'(px.green);
                red_sum[px.cluster]     += SUM_W'(px.red);
                pixel_count[px.cluster] += 1'b1;
            end
            if (!px.last_flag) return;
            n = clusters_in_use();
            for (int k = 0; k < n; k++) begin
                c.cluster    = CLU_W'(k);
                c.mean_blue  = mean_8p8(blue_sum[k], pixel_count[k]);
                c.mean_green = mean_8p8(green_sum[k], pixel_count[k]);
                c.mean_red   = mean_8p8(red_sum[k], pixel_count[k]);
                c.empty_flag = (pixel_count[k] == 0);
                c.last_flag  = (k == n - 1);
                pending      = {pending, c};
            end
            clear_sums();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, int cluster, int got, int want);
            if (got != want)
                report_mismatch($sformatf("cluster %0d %s got 0x%0h expected 0x%0h",
                                          cluster, name, got, want));
        endtask

        task check_result(t_centroid got);
            t_centroid want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected centroid for cluster %0d", got.cluster));
                return;
            end
            want = pending.pop_front();
            compare_field("cluster", int'(want.cluster), int'(got.cluster),
                          int'(want.cluster));
            compare_field("mean_blue", int'(want.cluster), int'(got.mean_blue),
                          int'(want.mean_blue));
            compare_field("mean_green", int'(want.cluster), int'(got.mean_green),
                          int'(want.mean_green));
            compare_field("mean_red", int'(want.cluster), int'(got.mean_red),
                          int'(want.mean_red));
            compare_field("empty_cluster", int'(want.cluster), int'(got.empty_flag),
                          int'(want.empty_flag));
            compare_field("last_result", int'(want.cluster), int'(got.last_flag),
                          int'(want.last_flag));
        endtask
    endclass

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wr_data   = '0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_stall;
    logic [CLU_W-1:0]  i_cluster_index = '0;
    logic [CH_W-1:0]   i_blue          = '0;
    logic [CH_W-1:0]   i_green         = '0;
    logic [CH_W-1:0]   i_red           = '0;
    logic              i_last_point    = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall     = 1'b0;
    logic [CLU_W-1:0]  o_out_cluster;
    logic [MEAN_W-1:0] o_mean_blue;
    logic [MEAN_W-1:0] o_mean_green;
    logic [MEAN_W-1:0] o_mean_red;
    logic              o_empty_cluster;
    logic              o_last_result;

    t_centroid_scoreboard sb;
    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    int                   cycle_count   = 0;

    kmeans_centroid_update_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cluster_index (i_cluster_index),
        .i_blue          (i_blue),
        .i_green         (i_green),
        .i_red           (i_red),
        .i_last_point    (i_last_point),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_cluster   (o_out_cluster),
        .o_mean_blue     (o_mean_blue),
        .o_mean_green    (o_mean_green),
        .o_mean_red      (o_mean_red),
        .o_empty_cluster (o_empty_cluster),
        .o_last_result   (o_last_result)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_centroid seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.cluster    = o_out_cluster;
            seen.mean_blue  = o_mean_blue;
            seen.mean_green = o_mean_green;
            seen.mean_red   = o_mean_red;
            seen.empty_flag = o_empty_cluster;
            seen.last_flag  = o_last_result;
            sb.check_result(seen);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cluster_index <= px.cluster;
        i_blue          <= px.blue;
        i_green         <= px.green;
        i_red           <= px.red;
        i_last_point    <= px.last_flag;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(px);
    endtask

    task automatic send_fields(input int cluster, input int b, input int g, input int r,
                               input bit last_flag);
        t_pixel px;
        px.cluster   = CLU_W'(cluster);
        px.blue      = CH_W'(b);
        px.green     = CH_W'(g);
        px.red       = CH_W'(r);
        px.last_flag = last_flag;
        send_pixel(px);
    endtask

    // The cluster count is only written once the previous frame has fully drained.
    task automatic write_cluster_count(input logic [CFG_W-1:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_cluster_count(value);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
        endcase
    endtask

    function automatic logic [CH_W-1:0] random_channel();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        return CH_W'($urandom_range(255));
    endfunction

    function automatic t_pixel random_pixel(input logic [CLU_W-1:0] previous, input bit last_flag);
        t_pixel px;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 30)
            px.cluster = previous;
        else if (pick < 90)
            px.cluster = CLU_W'($urandom_range(sb.clusters_in_use() - 1));
        else
            px.cluster = CLU_W'($urandom_range(MAX_CLUSTERS - 1));
        px.blue      = random_channel();
        px.green     = random_channel();
        px.red       = random_channel();
        px.last_flag = last_flag;
        return px;
    endfunction

    initial begin
        logic [CFG_W-1:0] phase_cc [8];
        t_pixel           px;
        int               sent;
        int               frame_len;

        sb = new();
        phase_cc = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd17, 5'd3, 5'd6, 5'd6};
        phase_cc[6] = CFG_W'($urandom_range(1, 16));
        set_idling(0);
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // Reset count of six: empty clusters, extreme channels and an unused index.
        send_fields(0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_fields(0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_fields(5, 8'h01, 8'h80, 8'hFE, 1'b0);
        send_fields(15, 8'hAA, 8'h55, 8'hAA, 1'b0);
        send_fields(3, 8'h55, 8'hAA, 8'h55, 1'b1);
        send_fields(2, 8'hFF, 8'h00, 8'hFF, 1'b1);
        write_cluster_count(5'd0);
        send_fields(15, 8'h12, 8'h34, 8'h56, 1'b0);
        send_fields(0, 8'h07, 8'h08, 8'h09, 1'b1);
        write_cluster_count(5'd31);
        send_fields(15, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_fields(15, 8'h01, 8'h02, 8'h03, 1'b1);
        write_cluster_count(5'd16);
        send_fields(7, 8'h80, 8'h7F, 8'h01, 1'b1);
        write_cluster_count(5'd17);
        send_fields(8, 8'hFE, 8'h01, 8'h80, 1'b1);

        for (int p = 0; p < 8; p++) begin
            write_cluster_count(phase_cc[p]);
            set_idling(p % 4);
            sent = 0;
            px   = '0;
            while (sent < 20) begin
                frame_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
                for (int i = 0; i < frame_len; i++) begin
                    px = random_pixel(px.cluster, i == frame_len - 1);
                    send_pixel(px);
                end
                sent += frame_len;
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
